FILE: rtl/rcpcs_pkg.sv
// ----------------------------------------------------------------------------
// rcpcs_pkg: shared types and constants
// Widths, opcodes and the request/status bundle of the serial mul/div unit.
// ----------------------------------------------------------------------------
package rcpcs_pkg;

    localparam int NUM_CAL    = 6;    // calibration registers, one per channel
    localparam int CFG_IDX_W  = 3;
    localparam int CAL_W      = 64;
    localparam int CH_W       = 3;
    localparam int TIME_W     = 32;
    localparam int PW_W       = 16;   // pulse width and calibration field width
    localparam int IN_TDATA_W = 40;
    localparam int OUT_W      = 16;
    localparam int VAL_W      = 18;   // mapped value before final truncation

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [VAL_W-1:0] DB_LO    = -18'sd5;
    localparam logic signed [VAL_W-1:0] DB_HI    = 18'sd5;
    localparam logic signed [VAL_W-1:0] FLOOR_LO = 18'sd750;
    localparam logic signed [VAL_W-1:0] FLOOR_HI = 18'sd1070;
    localparam logic signed [VAL_W-1:0] SAT_MAX  = 18'sd32767;

    typedef struct packed {
        logic            start;
        logic [PW_W-1:0] mcand;    // |out span|
        logic [PW_W-1:0] mplier;   // |clamped width - in_min|
        logic [PW_W-1:0] divisor;  // |in span|
    } md_req_t;

    typedef struct packed {
        logic            done;
        logic [PW_W-1:0] quotient;
    } md_stat_t;

endpackage

FILE: rtl/rc_pulse_capture_scaler_core.sv
// ----------------------------------------------------------------------------
// rc_pulse_capture_scaler_core: RC receiver pulse decoder and scaler
// Captures per-channel pulse widths from edge words and returns calibrated,
// scaled channel values on query words.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries input words. tuser is the opcode: edge or query.
//   An edge word records the start time (rising) or the 16-bit wrapped pulse
//   width (falling) for its channel in the accept cycle and gives no result.
//   A query word gives exactly one m_axis word: the channel's width clamped
//   to its calibration input range, mapped to the output range, then the
//   deadband (ch 0, 1, 3), saturating inversion (ch 0, 1) and throttle floor
//   (ch 2). An out-of-range channel returns 0.
//   A query passes through the clamp and prep states, the serial multiplier and
//   the serial restoring divider in rcpcs_muldiv, then the sum and output states
//   before m_axis_tvalid. An out-of-range query goes straight to the output
//   state. One query is in flight at a time.
//   cfg_we writes cal register cfg_index (0..5); write only while idle.
//   Reset clears all calibration, start times and widths.
//   A stalled m_axis holds its word; the core can finish the next query
//   and then waits until the output register frees up.
// ----------------------------------------------------------------------------
module rc_pulse_capture_scaler_core
    import rcpcs_pkg::*;
#(
    parameter int CHANNELS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // channel[2:0], pin_level[3],
                                                  // time_us[35:4], zero pad
    input  logic                  s_axis_tuser,   // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // scaled_value[15:0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CAL_W-1:0]      cfg_data
);

    localparam int NCH   = (CHANNELS < NUM_CAL) ? CHANNELS : NUM_CAL;
    localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLAMP = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_CALC  = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [CH_W-1:0] CH_AIL = 3'd0;
    localparam logic [CH_W-1:0] CH_ELE = 3'd1;
    localparam logic [CH_W-1:0] CH_THR = 3'd2;
    localparam logic [CH_W-1:0] CH_RUD = 3'd3;

    // input word fields
    logic [CH_W-1:0]   in_channel;
    logic              in_level;
    logic [TIME_W-1:0] in_time;
    logic              in_ok;
    logic              in_accept;
    logic [IDX_W-1:0]  in_idx;

    assign in_channel = s_axis_tdata[CH_W-1:0];
    assign in_level   = s_axis_tdata[CH_W];
    assign in_time    = s_axis_tdata[CH_W+TIME_W:CH_W+1];
    assign in_ok      = ({{(32-CH_W){1'b0}}, in_channel} < 32'(NCH));
    assign in_idx     = in_channel[IDX_W-1:0];

    // state
    logic [2:0]           state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CAL_W-1:0]     cal_reg [NUM_CAL];
    // only the low 16 bits of a start time reach the wrapped width
    logic [PW_W-1:0]      start_reg [NCH];
    logic [PW_W-1:0]      width_reg [NCH];

    // query payload
    logic [CH_W-1:0]          ch_reg;
    logic signed [PW_W-1:0]   wc_reg, in_min_reg, in_max_reg, out_min_reg, out_max_reg;
    logic                     neg_reg;
    logic                     span_zero_reg;
    logic signed [VAL_W-1:0]  v_reg;
    logic [OUT_W-1:0]         m_data_reg;

    md_req_t  md_req;
    md_stat_t md_stat;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // clamp
    logic [CAL_W-1:0]       cal_sel;
    logic signed [PW_W-1:0] w_raw, c_in_min, c_in_max, w_clamped;

    always_comb
    begin
        cal_sel  = cal_reg[ch_reg];
        w_raw    = $signed(width_reg[ch_reg[IDX_W-1:0]]);
        c_in_min = $signed(cal_sel[15:0]);
        c_in_max = $signed(cal_sel[31:16]);
        if (w_raw < c_in_min)
        begin
            w_clamped = c_in_min;
        end
        else if (w_raw > c_in_max)
        begin
            w_clamped = c_in_max;
        end
        else
        begin
            w_clamped = w_raw;
        end
    end

    // spans and their magnitudes for the serial unit
    logic signed [PW_W:0] num_a, span_in, span_out;
    logic [PW_W:0]        mag_a, mag_in, mag_out;

    always_comb
    begin
        num_a    = {wc_reg[PW_W-1], wc_reg} - {in_min_reg[PW_W-1], in_min_reg};
        span_in  = {in_max_reg[PW_W-1], in_max_reg} - {in_min_reg[PW_W-1], in_min_reg};
        span_out = {out_max_reg[PW_W-1], out_max_reg} - {out_min_reg[PW_W-1], out_min_reg};
        mag_a    = num_a[PW_W]    ? -num_a    : num_a;
        mag_in   = span_in[PW_W]  ? -span_in  : span_in;
        mag_out  = span_out[PW_W] ? -span_out : span_out;
        md_req.start   = (state_reg == ST_PREP);
        md_req.mplier  = mag_a[PW_W-1:0];
        md_req.mcand   = mag_out[PW_W-1:0];
        md_req.divisor = mag_in[PW_W-1:0];
    end

    rcpcs_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .stat  (md_stat)
    );

    // quotient back to a signed value plus out_min
    logic signed [VAL_W-1:0] q_signed, v_sum, out_min_ext;

    always_comb
    begin
        out_min_ext = VAL_W'(out_min_reg);
        q_signed    = neg_reg ? -$signed({2'b00, md_stat.quotient})
                              : $signed({2'b00, md_stat.quotient});
        v_sum       = span_zero_reg ? out_min_ext : (q_signed + out_min_ext);
    end

    // per-channel trims
    logic                    is_db, is_inv, is_flr;
    logic signed [VAL_W-1:0] v_db, v_neg, v_inv, v_fin;

    always_comb
    begin
        is_db  = ch_reg inside {CH_AIL, CH_ELE, CH_RUD};
        is_inv = ch_reg inside {CH_AIL, CH_ELE};
        is_flr = (ch_reg == CH_THR);
        v_db   = (is_db && v_reg > DB_LO && v_reg < DB_HI) ? '0 : v_reg;
        v_neg  = -v_db;
        if (is_inv)
        begin
            v_inv = (v_neg > SAT_MAX) ? SAT_MAX : v_neg;
        end
        else
        begin
            v_inv = v_db;
        end
        v_fin = (is_flr && v_inv > FLOOR_LO && v_inv < FLOOR_HI) ? FLOOR_HI : v_inv;
    end

    logic out_load;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    // control
    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && s_axis_tuser == OP_QUERY)
                begin
                    state_next = in_ok ? ST_CLAMP : ST_OUT;
                end
            end
            ST_CLAMP:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (md_stat.done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CAL; i++)
            begin
                cal_reg[i] <= '0;
            end
            for (int i = 0; i < NCH; i++)
            begin
                start_reg[i] <= '0;
                width_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && ({{(32-CFG_IDX_W){1'b0}}, cfg_index} < 32'(NUM_CAL)))
            begin
                cal_reg[cfg_index] <= cfg_data;
            end
            if (in_accept && s_axis_tuser == OP_EDGE && in_ok)
            begin
                if (in_level)
                begin
                    start_reg[in_idx] <= in_time[PW_W-1:0];
                end
                else
                begin
                    width_reg[in_idx] <= in_time[PW_W-1:0] - start_reg[in_idx];
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg <= in_channel;
            v_reg  <= '0;
        end
        if (state_reg == ST_CLAMP)
        begin
            wc_reg      <= w_clamped;
            in_min_reg  <= c_in_min;
            in_max_reg  <= c_in_max;
            out_min_reg <= $signed(cal_sel[47:32]);
            out_max_reg <= $signed(cal_sel[63:48]);
        end
        if (state_reg == ST_PREP)
        begin
            neg_reg       <= num_a[PW_W] ^ span_in[PW_W] ^ span_out[PW_W];
            span_zero_reg <= (span_in == '0);
        end
        if (state_reg == ST_SUM)
        begin
            v_reg <= v_sum;
        end
        if (out_load)
        begin
            m_data_reg <= v_fin[OUT_W-1:0];
        end
    end

endmodule

FILE: rtl/rcpcs_muldiv.sv
// ----------------------------------------------------------------------------
// rcpcs_muldiv: bit-serial unsigned multiply then divide
// 16 shift-add steps form the product, 16 restoring steps divide it; one
// accumulator register is shared by both phases.
// ----------------------------------------------------------------------------
module rcpcs_muldiv
    import rcpcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  md_req_t  req,
    output md_stat_t stat
);

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_MUL  = 2'd1;
    localparam logic [1:0] MD_DIV  = 2'd2;

    localparam int CNT_W = $clog2(PW_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PW_W - 1);

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [2*PW_W-1:0] acc_reg;
    logic [PW_W-1:0]   mcand_reg;
    logic [PW_W-1:0]   divisor_reg;

    logic [PW_W:0]     mul_sum;
    logic [PW_W:0]     div_sh;
    logic [PW_W+1:0]   div_trial;
    logic              div_ge;

    // multiply step: add into the upper half, shift right
    assign mul_sum = {1'b0, acc_reg[2*PW_W-1:PW_W]}
                   + (acc_reg[0] ? {1'b0, mcand_reg} : {(PW_W+1){1'b0}});

    // divide step: remainder in the upper half, quotient bits enter at the bottom
    assign div_sh    = acc_reg[2*PW_W-1:PW_W-1];
    assign div_trial = {1'b0, div_sh} - {2'b00, divisor_reg};
    assign div_ge    = ~div_trial[PW_W+1];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            MD_IDLE:
            begin
                cnt_next = '0;
                if (req.start)
                begin
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = MD_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    acc_reg     <= {{PW_W{1'b0}}, req.mplier};
                    mcand_reg   <= req.mcand;
                    divisor_reg <= req.divisor;
                end
            end
            MD_MUL:
            begin
                acc_reg <= {mul_sum, acc_reg[PW_W-1:1]};
            end
            MD_DIV:
            begin
                acc_reg <= {(div_ge ? div_trial[PW_W-1:0] : div_sh[PW_W-1:0]),
                            acc_reg[PW_W-2:0], div_ge};
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign stat.done     = done_reg;
    assign stat.quotient = acc_reg[PW_W-1:0];

endmodule

FILE: rtl/rcpcs_checker.sv
// ----------------------------------------------------------------------------
// rcpcs_checker: port-level checks for the pulse capture scaler
// Watches the stream ports only; bound to the core below.
// ----------------------------------------------------------------------------
module rcpcs_checker
    import rcpcs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_W-1:0]      m_axis_tdata
);

    // a stalled result word stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // and keeps its data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // a query blocks the input until its result is formed
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY |=> !s_axis_tready)
        else $error("input ready right after a query");

    // an edge word never makes a result
    a_edge_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_EDGE && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result after an edge word");

endmodule

bind rc_pulse_capture_scaler_core rcpcs_checker u_rcpcs_checker (.*);
